// ----- sv/sldr_pkg.sv -----
`default_nettype none
package sldr_pkg;

  localparam int CORD_W    = 34;
  localparam int DIV_W     = 48;
  localparam int DSR_W     = 12;
  localparam int RCP_W     = 23;
  localparam int DIG_W     = 16;
  localparam int DIV_STEPS = 2 * DIV_W / DIG_W;
  localparam int POS_SHIFT = 15;

  // reciprocals are floor(2^28 / divisor); 110592000 = 3375 << 15
  localparam logic [DSR_W-1:0]         LAT_DIVISOR = 12'd45;
  localparam logic [RCP_W-1:0]         LAT_RECIP   = 23'd5965232;
  localparam logic [DSR_W-1:0]         POS_DIVISOR = 12'd3375;
  localparam logic [RCP_W-1:0]         POS_RECIP   = 23'd79536;
  localparam logic signed [CORD_W-1:0] CORD_GAIN   = 34'sh026DD3B6A;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MAXD,
    S_SPEED,
    S_CORD_HD,
    S_SAVE_HD,
    S_DIV_LAT,
    S_SAVE_ANG,
    S_CORD_LAT,
    S_SAVE_LAT,
    S_MUL_VY,
    S_MUL_VX,
    S_MUL_VXL,
    S_MUL_PY,
    S_DINIT_Y,
    S_DIV_Y,
    S_SAVE_Y,
    S_MUL_PX,
    S_DINIT_X,
    S_DIV_X,
    S_SAVE_X,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAXD,
    OP_SPEED,
    OP_CSTEP,
    OP_CSAVE_HD,
    OP_DSTEP,
    OP_DSAVE_ANG,
    OP_CSAVE_LAT,
    OP_MUL_VY,
    OP_MUL_VX,
    OP_MUL_VXL,
    OP_MUL_PY,
    OP_DINIT_POS,
    OP_DSAVE_Y,
    OP_MUL_PX,
    OP_DSAVE_X,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic cord_last;
    logic div_last;
  } sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/sldr_if.sv -----
`default_nettype none
interface sldr_in_if;
  logic               valid;
  logic               ready;
  logic [23:0]        time_step;
  logic signed [31:0] requested_speed;
  logic [15:0]        heading;
  logic signed [31:0] latitude_in;
  logic signed [31:0] longitude_in;

  modport source (output valid, time_step, requested_speed, heading, latitude_in,
                  longitude_in, input ready);
  modport sink (input valid, time_step, requested_speed, heading, latitude_in,
                longitude_in, output ready);
endinterface

interface sldr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude_out;
  logic signed [31:0] longitude_out;
  logic signed [31:0] speed_out;

  modport source (output valid, latitude_out, longitude_out, speed_out, input ready);
  modport sink (input valid, latitude_out, longitude_out, speed_out, output ready);
endinterface

interface sldr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] accel_rate;

  modport source (output valid, accel_rate, input ready);
  modport sink (input valid, accel_rate, output ready);
endinterface
`default_nettype wire

// ----- sv/sldr_ctrl.sv -----
`default_nettype none
module sldr_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire sldr_pkg::sts_t sts,
  output sldr_pkg::cmd_t    cmd
);

  sldr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;

  assign out_load  = (state_r == sldr_pkg::S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sldr_pkg::S_IDLE:     if (in_valid) state_nxt = sldr_pkg::S_MAXD;
      sldr_pkg::S_MAXD:     state_nxt = sldr_pkg::S_SPEED;
      sldr_pkg::S_SPEED:    state_nxt = sldr_pkg::S_CORD_HD;
      sldr_pkg::S_CORD_HD:  if (sts.cord_last) state_nxt = sldr_pkg::S_SAVE_HD;
      sldr_pkg::S_SAVE_HD:  state_nxt = sldr_pkg::S_DIV_LAT;
      sldr_pkg::S_DIV_LAT:  if (sts.div_last) state_nxt = sldr_pkg::S_SAVE_ANG;
      sldr_pkg::S_SAVE_ANG: state_nxt = sldr_pkg::S_CORD_LAT;
      sldr_pkg::S_CORD_LAT: if (sts.cord_last) state_nxt = sldr_pkg::S_SAVE_LAT;
      sldr_pkg::S_SAVE_LAT: state_nxt = sldr_pkg::S_MUL_VY;
      sldr_pkg::S_MUL_VY:   state_nxt = sldr_pkg::S_MUL_VX;
      sldr_pkg::S_MUL_VX:   state_nxt = sldr_pkg::S_MUL_VXL;
      sldr_pkg::S_MUL_VXL:  state_nxt = sldr_pkg::S_MUL_PY;
      sldr_pkg::S_MUL_PY:   state_nxt = sldr_pkg::S_DINIT_Y;
      sldr_pkg::S_DINIT_Y:  state_nxt = sldr_pkg::S_DIV_Y;
      sldr_pkg::S_DIV_Y:    if (sts.div_last) state_nxt = sldr_pkg::S_SAVE_Y;
      sldr_pkg::S_SAVE_Y:   state_nxt = sldr_pkg::S_MUL_PX;
      sldr_pkg::S_MUL_PX:   state_nxt = sldr_pkg::S_DINIT_X;
      sldr_pkg::S_DINIT_X:  state_nxt = sldr_pkg::S_DIV_X;
      sldr_pkg::S_DIV_X:    if (sts.div_last) state_nxt = sldr_pkg::S_SAVE_X;
      sldr_pkg::S_SAVE_X:   state_nxt = sldr_pkg::S_DONE;
      sldr_pkg::S_DONE:     if (out_load) state_nxt = sldr_pkg::S_IDLE;
      default:              state_nxt = sldr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = sldr_pkg::OP_NONE;
    unique case (state_r)
      sldr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = sldr_pkg::OP_LOAD;
      end
      sldr_pkg::S_MAXD:     cmd.op = sldr_pkg::OP_MAXD;
      sldr_pkg::S_SPEED:    cmd.op = sldr_pkg::OP_SPEED;
      sldr_pkg::S_CORD_HD,
      sldr_pkg::S_CORD_LAT: cmd.op = sldr_pkg::OP_CSTEP;
      sldr_pkg::S_SAVE_HD:  cmd.op = sldr_pkg::OP_CSAVE_HD;
      sldr_pkg::S_DIV_LAT,
      sldr_pkg::S_DIV_Y,
      sldr_pkg::S_DIV_X:    cmd.op = sldr_pkg::OP_DSTEP;
      sldr_pkg::S_SAVE_ANG: cmd.op = sldr_pkg::OP_DSAVE_ANG;
      sldr_pkg::S_SAVE_LAT: cmd.op = sldr_pkg::OP_CSAVE_LAT;
      sldr_pkg::S_MUL_VY:   cmd.op = sldr_pkg::OP_MUL_VY;
      sldr_pkg::S_MUL_VX:   cmd.op = sldr_pkg::OP_MUL_VX;
      sldr_pkg::S_MUL_VXL:  cmd.op = sldr_pkg::OP_MUL_VXL;
      sldr_pkg::S_MUL_PY:   cmd.op = sldr_pkg::OP_MUL_PY;
      sldr_pkg::S_DINIT_Y,
      sldr_pkg::S_DINIT_X:  cmd.op = sldr_pkg::OP_DINIT_POS;
      sldr_pkg::S_SAVE_Y:   cmd.op = sldr_pkg::OP_DSAVE_Y;
      sldr_pkg::S_MUL_PX:   cmd.op = sldr_pkg::OP_MUL_PX;
      sldr_pkg::S_SAVE_X:   cmd.op = sldr_pkg::OP_DSAVE_X;
      sldr_pkg::S_DONE:     if (out_load) cmd.op = sldr_pkg::OP_OUT;
      default:              cmd.op = sldr_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sldr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sldr_dp.sv -----
`default_nettype none
module sldr_dp #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sldr_pkg::cmd_t     cmd,
  output sldr_pkg::sts_t          sts,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [23:0]        time_step,
  input  wire logic signed [31:0] requested_speed,
  input  wire logic [15:0]        heading,
  input  wire logic signed [31:0] latitude_in,
  input  wire logic signed [31:0] longitude_in,
  output logic signed [31:0]      latitude_out,
  output logic signed [31:0]      longitude_out,
  output logic signed [31:0]      speed_out
);

  localparam int CW = sldr_pkg::CORD_W;
  localparam int DW = sldr_pkg::DIV_W;
  localparam int SW = sldr_pkg::DSR_W;
  localparam int RW = sldr_pkg::RCP_W;
  localparam int GW = sldr_pkg::DIG_W;
  localparam int PW = GW + SW + RW;

  function automatic logic signed [31:0] sat32(input logic signed [DW:0] v);
    logic signed [31:0] r;
    if (v > $signed((DW+1)'(33'sh07FFFFFFF))) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -$signed((DW+1)'(33'sh080000000))) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [31:0]        accel_r;
  logic [23:0]        t_r;
  logic signed [31:0] req_r, lat_r, lng_r, speed_r, speed_nxt;
  logic [15:0]        hd_r;
  logic [39:0]        maxd_r;

  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic                 flip_r;
  logic [5:0]           cnt_r;
  logic signed [CW-1:0] ch_r, sh_r, cl_r;

  logic [SW-1:0]  rem_r;
  logic [DW-1:0]  dvd_r, q_r;
  logic           neg_r;
  logic [SW-1:0]  dsr_r;
  logic [RW-1:0]  rcp_r;
  logic [PW-1:0]  prod_r;

  logic signed [CW-1:0] vy_r, vx_r, vxl_r;
  logic signed [58:0]   p_r;
  logic signed [31:0]   nlat_r, nlng_r;

  logic [55:0]          maxd_prod;
  logic signed [32:0]   delta;
  logic [32:0]          mag;
  logic [31:0]          ang, ang_q;
  logic                 ang_flip;
  logic signed [CW-1:0] dx, dy, at;
  logic [GW+SW-1:0]     dv;
  logic [PW-1:0]        dprod;
  logic [GW:0]          q_est, q_dig;
  logic [GW+SW:0]       d_back, r_est, r_fix;
  logic                 d_up;
  logic signed [DW:0]   q_s;
  logic signed [37:0]   lat64;
  logic [37:0]          lat64_mag;
  logic [58:0]          p_mag;
  logic signed [65:0]   m_vy, m_vx;
  logic signed [67:0]   m_vxl;
  logic signed [58:0]   m_p;

  assign sts.cord_last = (cnt_r == 6'(CORDIC_ITERATIONS - 1));
  assign sts.div_last  = (cnt_r == 6'(sldr_pkg::DIV_STEPS - 1));

  assign maxd_prod = 56'(t_r) * 56'(accel_r);
  assign delta     = {req_r[31], req_r} - {speed_r[31], speed_r};
  assign mag       = delta[32] ? 33'(-delta) : 33'(delta);

  always_comb begin
    if ({7'b0, mag} <= maxd_r) begin
      speed_nxt = req_r;
    end else if (!delta[32]) begin
      speed_nxt = speed_r + $signed(maxd_r[31:0]);
    end else begin
      speed_nxt = speed_r - $signed(maxd_r[31:0]);
    end
  end

  assign q_s      = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign ang_q    = q_s[31:0];
  assign ang      = (cmd.op == sldr_pkg::OP_SPEED) ? {hd_r, 16'b0} : ang_q;
  assign ang_flip = ang[31] ^ ang[30];

  assign dx = cy_r >>> cnt_r[4:0];
  assign dy = cx_r >>> cnt_r[4:0];
  assign at = $signed({2'b0, sldr_pkg::atan_turn(cnt_r[4:0])});

  // each 16-bit digit: registered reciprocal estimate, then one correction
  assign dv     = {rem_r, dvd_r[DW-1 -: GW]};
  assign dprod  = PW'(dv) * PW'(rcp_r);
  assign q_est  = prod_r[2*GW+SW:GW+SW];
  assign d_back = (GW+SW+1)'(q_est) * (GW+SW+1)'(dsr_r);
  assign r_est  = {1'b0, dv} - d_back;
  assign d_up   = (r_est >= (GW+SW+1)'(dsr_r));
  assign r_fix  = d_up ? (r_est - (GW+SW+1)'(dsr_r)) : r_est;
  assign q_dig  = q_est + (GW+1)'(d_up);

  assign lat64     = {lat_r, 6'b0};
  assign lat64_mag = lat64[37] ? 38'(-lat64) : 38'(lat64);
  assign p_mag     = p_r[58] ? 59'(-p_r) : 59'(p_r);

  assign m_vy  = speed_r * ch_r;
  assign m_vx  = speed_r * sh_r;
  assign m_vxl = vx_r * cl_r;
  assign m_p   = (cmd.op == sldr_pkg::OP_MUL_PY ? vy_r : vxl_r) * $signed({1'b0, t_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= 32'd65536;
      speed_r <= '0;
    end else begin
      if (cfg_we) accel_r <= cfg_data;
      if (cmd.op == sldr_pkg::OP_SPEED) speed_r <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      sldr_pkg::OP_LOAD: begin
        t_r   <= time_step;
        req_r <= requested_speed;
        hd_r  <= heading;
        lat_r <= latitude_in;
        lng_r <= longitude_in;
      end
      sldr_pkg::OP_MAXD: maxd_r <= maxd_prod[55:16];
      sldr_pkg::OP_SPEED, sldr_pkg::OP_DSAVE_ANG: begin
        cx_r   <= sldr_pkg::CORD_GAIN;
        cy_r   <= '0;
        cz_r   <= CW'($signed(ang_flip ? (ang ^ 32'h80000000) : ang));
        flip_r <= ang_flip;
        cnt_r  <= '0;
      end
      sldr_pkg::OP_CSTEP: begin
        if (!cz_r[CW-1]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + at;
        end
        cnt_r <= cnt_r + 6'd1;
      end
      sldr_pkg::OP_CSAVE_HD: begin
        ch_r  <= flip_r ? -cx_r : cx_r;
        sh_r  <= flip_r ? -cy_r : cy_r;
        dvd_r <= DW'(lat64_mag);
        neg_r <= lat_r[31];
        dsr_r <= sldr_pkg::LAT_DIVISOR;
        rcp_r <= sldr_pkg::LAT_RECIP;
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= '0;
      end
      sldr_pkg::OP_DINIT_POS: begin
        dvd_r <= DW'(p_mag[58:sldr_pkg::POS_SHIFT]);
        neg_r <= p_r[58];
        dsr_r <= sldr_pkg::POS_DIVISOR;
        rcp_r <= sldr_pkg::POS_RECIP;
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= '0;
      end
      sldr_pkg::OP_DSTEP: begin
        if (!cnt_r[0]) begin
          prod_r <= dprod;
        end else begin
          rem_r <= r_fix[SW-1:0];
          dvd_r <= {dvd_r[DW-GW-1:0], {GW{1'b0}}};
          q_r   <= {q_r[DW-GW-1:0], q_dig[GW-1:0]};
        end
        cnt_r <= cnt_r + 6'd1;
      end
      sldr_pkg::OP_CSAVE_LAT: cl_r  <= flip_r ? -cx_r : cx_r;
      sldr_pkg::OP_MUL_VY:    vy_r  <= CW'(m_vy >>> 30);
      sldr_pkg::OP_MUL_VX:    vx_r  <= CW'(m_vx >>> 30);
      sldr_pkg::OP_MUL_VXL:   vxl_r <= CW'(m_vxl >>> 30);
      sldr_pkg::OP_MUL_PY, sldr_pkg::OP_MUL_PX: p_r <= m_p;
      sldr_pkg::OP_DSAVE_Y:   nlat_r <= sat32($signed((DW+1)'(lat_r)) + q_s);
      sldr_pkg::OP_DSAVE_X:   nlng_r <= sat32($signed((DW+1)'(lng_r)) + q_s);
      sldr_pkg::OP_OUT: begin
        latitude_out  <= nlat_r;
        longitude_out <= nlng_r;
        speed_out     <= speed_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/slew_limited_dead_reckoning.sv -----
// channel | dir | handshake            | payload
// in_if   | in  | valid/ready          | time_step, requested_speed, heading, lat/lon in
// out_if  | out | valid/ready          | latitude_out, longitude_out, speed_out
// cfg_if  | in  | valid/ready (ready=1)| accel_rate
// Between acceptance and result a transaction runs two passes of the shared CORDIC
// and three reciprocal divides.
// The next input can be taken in the cycle after the result enters the output register.
// Synchronous active-low reset: speed 0, accel_rate 1.0 kn/s, no result pending.
// A stalled result holds; the next transaction runs meanwhile and waits at the end.
`default_nettype none
module slew_limited_dead_reckoning #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sldr_in_if.sink   in_if,
  sldr_out_if.source out_if,
  sldr_cfg_if.sink  cfg_if
);

  sldr_pkg::cmd_t cmd;
  sldr_pkg::sts_t sts;

  assign cfg_if.ready = 1'b1;

  sldr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sldr_dp #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_if.valid),
    .cfg_data        (cfg_if.accel_rate),
    .time_step       (in_if.time_step),
    .requested_speed (in_if.requested_speed),
    .heading         (in_if.heading),
    .latitude_in     (in_if.latitude_in),
    .longitude_in    (in_if.longitude_in),
    .latitude_out    (out_if.latitude_out),
    .longitude_out   (out_if.longitude_out),
    .speed_out       (out_if.speed_out)
  );

endmodule
`default_nettype wire

// ----- sv/sldr_chk.sv -----
`default_nettype none
module sldr_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_lat,
  input wire logic [31:0] out_lng,
  input wire logic [31:0] out_spd,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lat) && $stable(out_lng)
      && $stable(out_spd))
    else $error("stalled result changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken while busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a transaction in progress");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind slew_limited_dead_reckoning sldr_chk u_sldr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_lat   (out_if.latitude_out),
  .out_lng   (out_if.longitude_out),
  .out_spd   (out_if.speed_out),
  .cfg_valid (cfg_if.valid),
  .cfg_ready (cfg_if.ready)
);
`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none
module tb;

  localparam int CORD_ITERS = 24;
  localparam int RESULT_LAT = 2 * CORD_ITERS + 33;
  localparam longint POS_DIV = 110592000;

  typedef struct {
    logic [23:0] t;
    logic [31:0] req;
    logic [15:0] hd;
    logic [31:0] lat;
    logic [31:0] lng;
  } tick_t;

  typedef struct {
    logic [31:0] lat;
    logic [31:0] lng;
    logic [31:0] spd;
  } fix_t;

  typedef struct {
    bit          is_cfg;
    logic [31:0] rate;
    tick_t       tk;
    bit          typed;
    fix_t        fx;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sldr_in_if  in_bus();
  sldr_out_if out_bus();
  sldr_cfg_if cfg_bus();

  slew_limited_dead_reckoning #(.CORDIC_ITERATIONS(CORD_ITERS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  always #5 clk = ~clk;

  fix_t        fix_q[$];
  longint      kept_speed;
  logic [31:0] slew_rate;
  int          errors = 0;
  int          stall_left = 0;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.time_step = '0;
    in_bus.requested_speed = '0;
    in_bus.heading = '0;
    in_bus.latitude_in = '0;
    in_bus.longitude_in = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.accel_rate = '0;
  end

  function automatic longint turn_atan(int i);
    return longint'(sldr_pkg::atan_turn(5'(i)));
  endfunction

  // cos/sin in Q2.30 of a 32-bit turn angle
  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    bit          flip;
    logic [31:0] a;
    longint      x, y, z, dx, dy;
    flip = ang[31] ^ ang[30];
    a = flip ? ang - 32'h8000_0000 : ang;
    z = longint'($signed(a));
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < (CORD_ITERS > 32 ? 32 : CORD_ITERS); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_atan(i);
      end else begin
        x += dx; y -= dy; z += turn_atan(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic fix_t advance_fix(tick_t tk);
    longint t, req, lat, lng, maxd, gap, mag, ch, sh, cl, sl, vy, vx, vxl;
    logic [31:0] lat_ang;
    fix_t f;
    t = longint'(tk.t);
    req = longint'($signed(tk.req));
    lat = longint'($signed(tk.lat));
    lng = longint'($signed(tk.lng));
    maxd = longint'((64'(tk.t) * 64'(slew_rate)) >> 16);
    gap = req - kept_speed;
    mag = gap < 0 ? -gap : gap;
    if (mag <= maxd) kept_speed = req;
    else if (gap > 0) kept_speed += maxd;
    else kept_speed -= maxd;
    rotate({tk.hd, 16'h0}, ch, sh);
    lat_ang = 32'((lat * 64) / 45);
    rotate(lat_ang, cl, sl);
    vy = (kept_speed * ch) >>> 30;
    vx = (kept_speed * sh) >>> 30;
    vxl = (vx * cl) >>> 30;
    f.lat = 32'(clip32(lat + (vy * t) / POS_DIV));
    f.lng = 32'(clip32(lng + (vxl * t) / POS_DIV));
    f.spd = 32'(kept_speed);
    return f;
  endfunction

  // result side: random back-pressure with quiet stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 400)
                                                  : $urandom_range(1, 4);
    end
  end

  always @(posedge clk) begin
    fix_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (fix_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = fix_q.pop_front();
        if (out_bus.latitude_out !== e.lat) begin
          $error("latitude_out exp %h got %h", e.lat, out_bus.latitude_out);
          errors++;
        end
        if (out_bus.longitude_out !== e.lng) begin
          $error("longitude_out exp %h got %h", e.lng, out_bus.longitude_out);
          errors++;
        end
        if (out_bus.speed_out !== e.spd) begin
          $error("speed_out exp %h got %h", e.spd, out_bus.speed_out);
          errors++;
        end
      end
    end
  end

  task automatic send_tick(tick_t tk, int gap, bit typed, fix_t fx);
    fix_t f;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.time_step <= tk.t;
    in_bus.requested_speed <= tk.req;
    in_bus.heading <= tk.hd;
    in_bus.latitude_in <= tk.lat;
    in_bus.longitude_in <= tk.lng;
    do @(posedge clk); while (!in_bus.ready);
    f = advance_fix(tk);
    fix_q.push_back(typed ? fx : f);
  endtask

  task automatic write_rate(logic [31:0] r);
    in_bus.valid <= 1'b0;
    wait (fix_q.size() == 0);
    repeat (RESULT_LAT) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.accel_rate <= r;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    slew_rate = r;
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 300);
  endfunction

  function automatic tick_t rand_tick();
    tick_t tk;
    case ($urandom_range(0, 3))
      0: tk.t = 24'($urandom());
      1: tk.t = 24'($urandom_range(0, 24'h1_FFFF));
      2: tk.t = 24'hFF_FFFF;
      default: tk.t = 24'($urandom_range(0, 24'h0F_FFFF));
    endcase
    case ($urandom_range(0, 4))
      0: tk.req = $urandom();
      1: tk.req = 32'(kept_speed + $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
      2: tk.req = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: tk.req = 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      default: tk.req = 32'(kept_speed);
    endcase
    tk.hd = 16'($urandom());
    case ($urandom_range(0, 3))
      0: tk.lat = $urandom();
      1: tk.lat = 32'($signed($urandom_range(0, 32'h5000_0000)) - 32'sh2800_0000);
      2: tk.lat = ($urandom_range(0, 1) ? 32'h5A00_0000 : 32'hA600_0000) + $urandom_range(0, 255) - 128;
      default: tk.lat = $urandom_range(0, 1) ? 32'h7FFF_FF00 + $urandom_range(0, 255)
                                             : 32'h8000_0000 + $urandom_range(0, 255);
    endcase
    tk.lng = $urandom_range(0, 2) == 0
             ? ($urandom_range(0, 1) ? 32'h7FFF_0000 + $urandom_range(0, 16'hFFFF)
                                     : 32'h8000_0000 + $urandom_range(0, 16'hFFFF))
             : $urandom();
    return tk;
  endfunction

  row_t plan[] = '{
    '{0, 0, '{24'h0, 32'h0, 16'h0, 32'h5, 32'h7}, 1, '{32'h5, 32'h7, 32'h0}},
    '{0, 0, '{24'h0, 32'h7FFF_FFFF, 16'h0, 32'h0, 32'h0}, 1, '{32'h0, 32'h0, 32'h0}},
    '{0, 0, '{24'hFF_FFFF, 32'h7FFF_FFFF, 16'h0, 32'h0, 32'h0}, 0, '{0, 0, 0}},
    '{0, 0, '{24'h01_0000, 32'h8000_0000, 16'h4000, 32'h7FFF_FFFF, 32'h0}, 0, '{0, 0, 0}},
    '{0, 0, '{24'hFF_FFFF, 32'h0, 16'h8000, 32'h8000_0000, 32'h8000_0000}, 0, '{0, 0, 0}},
    '{0, 0, '{24'h80_0000, 32'h0012_3456, 16'hC000, 32'h5A00_0000, 32'h7FFF_FFFF}, 0, '{0, 0, 0}},
    '{0, 0, '{24'h00_0001, 32'h0, 16'hFFFF, 32'hA600_0000, 32'h1234_5678}, 0, '{0, 0, 0}},
    '{1, 32'hFFFF_FFFF, '{0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
    '{0, 0, '{24'hFF_FFFF, 32'h7FFF_FFFF, 16'h0, 32'h7F00_0000, 32'h0}, 0, '{0, 0, 0}},
    '{0, 0, '{24'hFF_FFFF, 32'h7FFF_FFFF, 16'h4000, 32'h0, 32'h7F00_0000}, 0, '{0, 0, 0}},
    '{0, 0, '{24'hFF_FFFF, 32'h8000_0000, 16'h0, 32'h8100_0000, 32'h0}, 0, '{0, 0, 0}},
    '{0, 0, '{24'hFF_FFFF, 32'h8000_0000, 16'h4000, 32'h0, 32'h8100_0000}, 0, '{0, 0, 0}},
    '{0, 0, '{24'hFF_FFFF, 32'h8000_0000, 16'h2000, 32'hC000_0000, 32'h0}, 0, '{0, 0, 0}},
    '{1, 32'h0, '{0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
    '{0, 0, '{24'hFF_FFFF, 32'h0, 16'h6000, 32'h1234_5678, 32'h0}, 0, '{0, 0, 0}},
    '{0, 0, '{24'hFF_FFFF, 32'h7FFF_FFFF, 16'hA000, 32'h0, 32'h0}, 0, '{0, 0, 0}}
  };

  logic [31:0] rates[4] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0000_0100};

  initial begin
    fix_t none;
    kept_speed = 0;
    slew_rate = 32'h0001_0000;
    none = '{0, 0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_rate(plan[i].rate);
      else send_tick(plan[i].tk, rand_gap(), plan[i].typed, plan[i].fx);
    end
    for (int ph = 0; ph < 5; ph++) begin
      write_rate(ph < 4 ? rates[ph] : $urandom());
      for (int n = 0; n < 345; n++) send_tick(rand_tick(), rand_gap(), 0, none);
    end
    in_bus.valid <= 1'b0;
    wait (fix_q.size() == 0);
    repeat (RESULT_LAT) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
